[hdl/smra_pkg.sv]
`default_nettype none

package smra_pkg;

  // Field widths of the stream items.
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = 16;
  localparam int unsigned SumW    = 24;
  localparam int unsigned GainW   = 17;
  localparam int unsigned ColOutW = 10;
  localparam int unsigned OutW    = 16;

  // Configuration register widths and indexes.
  localparam int unsigned RowWidthW = 11;
  localparam int unsigned RowsW     = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 17;

  localparam logic [CfgIdxW-1:0] CFG_ROW_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS_AVG  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AVG_GAIN  = 2'd2;

  localparam logic [RowWidthW-1:0] RowWidthRst = 11'd1;
  localparam logic [RowsW-1:0]     RowsRst     = 9'd1;
  localparam logic [GainW-1:0]     GainRst     = 17'h10000;

  // Square root takes two radicand bits per iteration.
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned SqrtCntW  = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sq_load;
    logic sqrt_step;
    logic sum_en;
    logic mul_en;
    logic out_load;
  } smra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_row;
    logic out_free;
  } smra_sts_t;

endpackage

`default_nettype wire

[hdl/smra_ctrl.sv]
`default_nettype none

module smra_ctrl
  import smra_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire smra_sts_t sts_i,
  output smra_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [SqrtCntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and the commands of each state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.sq_load = 1'b1;
        cnt_d         = '0;
        state_d       = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SqrtCntW'(SqrtSteps - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = sts_i.last_row ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // A new request starts with the squaring step.
  a_accept_to_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_SQ)
    else $error("accepted request did not start squaring");

  // The accumulate step follows only the last square root iteration.
  a_sum_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> $past(state_q) == ST_SQRT &&
                          $past(cnt_q) == SqrtCntW'(SqrtSteps - 1))
    else $error("accumulate step entered early");

  // A result is loaded only into a free output slot.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free && state_q == ST_EMIT)
    else $error("result loaded into busy output slot");

endmodule

`default_nettype wire

[hdl/smra_dp.sv]
`default_nettype none

module smra_dp
  import smra_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_AVERAGE = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire smra_cmd_t             cmd_i,
  output smra_sts_t                  sts_o,
  input  wire logic [SampleW-1:0]    sample_real_i,
  input  wire logic [SampleW-1:0]    sample_imag_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OutW-1:0]            avg_magnitude_o,
  output logic [ColOutW-1:0]         column_index_o,
  output logic                       row_done_o
);

  localparam int unsigned ColW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RowW  = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;
  localparam int unsigned ProdW = SumW + GainW;
  localparam int unsigned RemW  = MagW + 3;
  localparam int unsigned RadW  = 2 * SampleW;

  // Configuration registers.
  logic [RowWidthW-1:0] row_width_q;
  logic [RowsW-1:0]     rows_q;
  logic [GainW-1:0]     gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthRst;
      rows_q      <= RowsRst;
      gain_q      <= GainRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[RowWidthW-1:0];
        CFG_ROWS_AVG:  rows_q      <= cfg_data_i[RowsW-1:0];
        CFG_AVG_GAIN:  gain_q      <= cfg_data_i[GainW-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp the geometry to its legal range and form the last indexes.
  logic [31:0]     width_cl, rows_cl;
  logic [ColW-1:0] width_m1;
  logic [RowW-1:0] rows_m1;

  always_comb begin
    if (row_width_q == '0) begin
      width_cl = 32'd1;
    end else if (32'(row_width_q) > 32'(MAX_COLUMNS)) begin
      width_cl = 32'(MAX_COLUMNS);
    end else begin
      width_cl = 32'(row_width_q);
    end
    if (rows_q == '0) begin
      rows_cl = 32'd1;
    end else if (32'(rows_q) > 32'(MAX_AVERAGE)) begin
      rows_cl = 32'(MAX_AVERAGE);
    end else begin
      rows_cl = 32'(rows_q);
    end
  end

  assign width_m1 = ColW'(width_cl - 32'd1);
  assign rows_m1  = RowW'(rows_cl - 32'd1);

  // Column and row position of the incoming bin.
  logic [ColW-1:0] col_cnt_q, col_now, col_q;
  logic [RowW-1:0] row_q;
  logic            last_col, last_row, last_col_q, last_row_q, row_zero_q;

  assign last_col = (col_cnt_q >= width_m1);
  assign last_row = (row_q >= rows_m1);
  assign col_now  = last_col ? width_m1 : col_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_q     <= '0;
    end else if (cmd_i.accept) begin
      if (last_col) begin
        col_cnt_q <= '0;
        row_q     <= last_row ? '0 : row_q + 1'b1;
      end else begin
        col_cnt_q <= col_now + 1'b1;
      end
    end
  end

  // Per-request flags and the operand magnitudes.
  logic [SampleW-1:0] pr_q, pi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q      <= col_now;
      last_col_q <= last_col;
      last_row_q <= last_row;
      row_zero_q <= (row_q == '0);
      pr_q       <= sample_real_i[SampleW-1] ? SampleW'(-sample_real_i) : sample_real_i;
      pi_q       <= sample_imag_i[SampleW-1] ? SampleW'(-sample_imag_i) : sample_imag_i;
    end
  end

  // Column sum memory: read on accept, written in the accumulate step.
  logic [SumW-1:0] sum_mem [MAX_COLUMNS];
  logic [SumW-1:0] rd_q, sum_d, sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= sum_mem[col_now];
    end
    if (cmd_i.sum_en) begin
      sum_mem[col_q] <= sum_d;
    end
  end

  // Digit-by-digit square root, two radicand bits per iteration.
  logic [RadW-1:0] rad_q;
  logic [RemW-1:0] rem_q, rem_sh, trial;
  logic [MagW-1:0] root_q;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_load) begin
      rad_q  <= (RadW'(pr_q) * RadW'(pr_q)) + (RadW'(pi_q) * RadW'(pi_q));
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[MagW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[MagW-2:0], 1'b0};
      end
    end
  end

  // Accumulate with saturation; the first row of a group overwrites.
  logic [SumW:0] sum_add;

  assign sum_add = {1'b0, rd_q} + (SumW + 1)'(root_q);

  always_comb begin
    if (row_zero_q) begin
      sum_d = SumW'(root_q);
    end else if (sum_add[SumW]) begin
      sum_d = '1;
    end else begin
      sum_d = sum_add[SumW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  // Gain multiply, registered before scaling.
  logic [ProdW-1:0] prod_q;
  logic [ProdW-17:0] scaled;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(sum_q) * ProdW'(gain_q);
    end
  end

  assign scaled = prod_q[ProdW-1:16];

  // Output register: holds a result until the receiver takes it.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      avg_magnitude_o <= (|scaled[ProdW-17:OutW]) ? '1 : scaled[OutW-1:0];
      column_index_o  <= ColOutW'(col_q);
      row_done_o      <= last_col_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.last_row = last_row_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // A loaded result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o)
    else $error("loaded result not offered");

  // The stored column never passes the last column of the row.
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> col_q <= $past(width_m1))
    else $error("column beyond row width");

  // A result is produced only for the last row of a group.
  a_mul_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_en |-> last_row_q)
    else $error("result produced outside last row");

endmodule

`default_nettype wire

[hdl/spectrum_magnitude_row_averager_unit.sv]
// Spectrum magnitude row averager.
// Input stream s_axis carries one complex spectrum bin per request, rows in
// row-major order. Output stream m_axis carries one averaged magnitude per
// bin of the last row of each group of rows_per_average rows; tlast marks
// the last column of an output row. Bins of other rows produce no output.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i; the
// user must do so only while the block is idle, which the block itself
// does not enforce; indexes 0, 1 and 2 select row width, rows per average
// and the Q16 gain. Each bin passes through a squaring step, 16 iterations
// of the shared square root unit, one column memory update and a return to
// idle; bins that produce a result add one gain multiply and one output
// load. A new bin is accepted only once the block is back in idle. Results
// sit in an output register; the next bin is accepted while a result waits.
// If the receiver stalls, the next result holds the block until the
// register is free. Reset clears the counters and output valid and restores
// the registers to width 1, one row, gain 1.0; the column sum memory needs
// no clearing since the first row of a group overwrites it.
`default_nettype none

module spectrum_magnitude_row_averager_unit
  import smra_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_AVERAGE = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,  // sample_real[15:0], sample_imag[31:16]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,  // avg_magnitude[15:0], column_index[25:16]
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  smra_cmd_t          cmd;
  smra_sts_t          sts;
  logic [OutW-1:0]    avg_magnitude;
  logic [ColOutW-1:0] column_index;

  smra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smra_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_AVERAGE (MAX_AVERAGE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_real_i   (s_axis_tdata[15:0]),
    .sample_imag_i   (s_axis_tdata[31:16]),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .avg_magnitude_o (avg_magnitude),
    .column_index_o  (column_index),
    .row_done_o      (m_axis_tlast)
  );

  // Pack the result fields, padded to whole bytes.
  assign m_axis_tdata = {6'd0, column_index, avg_magnitude};

endmodule

`default_nettype wire
